// File: rtl/worf_pkg.sv
// worf_pkg: shared widths, codes and item types of the window outlier reject filter
// no dependencies; used by every module of the filter
`timescale 1ns / 1ps
`default_nettype none

package worf_pkg;

	// field widths
	localparam int TIME_W = 32;
	localparam int VAL_W  = 24;

	// five-sample window
	localparam int WIN_LEN = 5;

	// exact statistics widths (all values proven to fit)
	localparam int SUM_W  = 27;	// window sum, signed
	localparam int SQ_W   = 47;	// one square, unsigned
	localparam int QSUM_W = 49;	// sum of squares, unsigned
	localparam int DIFF_W = 28;	// 5v - S, signed
	localparam int DSQ_W  = 53;	// (5v - S)^2, unsigned
	localparam int VAR_W  = 51;	// 5Q - S^2 and S^2, unsigned

	// sample counter and its thresholds
	localparam int SEEN_W = 3;
	localparam logic [SEEN_W-1:0] SEEN_HEAD = 3'd2;	// below this a sample passes at once
	localparam logic [SEEN_W-1:0] SEEN_TAIL = 3'd3;	// held sample exists on a short series end
	localparam logic [SEEN_W-1:0] SEEN_TEST = 3'd4;	// from here the center sample is tested
	localparam logic [SEEN_W-1:0] SEEN_MAX  = 3'd5;

	// front pipeline
	localparam int PIPE_STAGES = 4;
	localparam int INFL_W      = 3;

	// default depth of the job queue
	localparam int QUEUE_DEPTH = 8;

	// result slots of one job, emitted in this order
	localparam int SLOT_A = 0;	// center sample of the window
	localparam int SLOT_B = 1;	// sample before the newest
	localparam int SLOT_C = 2;	// newest sample
	localparam int SLOTS  = 3;

	typedef struct packed {
		logic [TIME_W-1:0]       stamp;
		logic signed [VAL_W-1:0] value;
	} slot_t;

	typedef struct packed {
		slot_t            slot_c;
		slot_t            slot_b;
		slot_t            slot_a;
		logic [SLOTS-1:0] en;
		logic             tested;
		logic             last;
	} job_t;

endpackage

`default_nettype wire

// File: rtl/worf_queue.sv
// worf_queue: short job queue between the classifying front and the emitting back
// depends on worf_pkg (job_t)
`timescale 1ns / 1ps
`default_nettype none

module worf_queue #(
	parameter int DEPTH = worf_pkg::QUEUE_DEPTH,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire worf_pkg::job_t  push_job,
	input  wire logic            pop,
	output worf_pkg::job_t       head,
	output logic                 empty,
	output logic [CNT_W-1:0]     count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	worf_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	// the credit check upstream must keep pushes away from a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_W'(DEPTH)))
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// File: rtl/worf_front.sv
// worf_front: sample window, exact mean/deviation test pipeline and job classification
// depends on worf_pkg (widths, thresholds, job_t)
`timescale 1ns / 1ps
`default_nettype none

module worf_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire logic [worf_pkg::TIME_W-1:0]       sample_time,
	input  wire logic signed [worf_pkg::VAL_W-1:0] sample_value,
	input  wire logic                              series_end,
	output logic                                   push,
	output worf_pkg::job_t                         push_job,
	output logic [worf_pkg::INFL_W-1:0]            inflight
);

	localparam int TW     = worf_pkg::TIME_W;
	localparam int VW     = worf_pkg::VAL_W;
	localparam int WIN    = worf_pkg::WIN_LEN;
	localparam int SUM_W  = worf_pkg::SUM_W;
	localparam int SQ_W   = worf_pkg::SQ_W;
	localparam int QSUM_W = worf_pkg::QSUM_W;
	localparam int DIFF_W = worf_pkg::DIFF_W;
	localparam int DSQ_W  = worf_pkg::DSQ_W;
	localparam int VAR_W  = worf_pkg::VAR_W;
	localparam int INFL_W = worf_pkg::INFL_W;

	// window of original values, index WIN-1 newest
	logic signed [VW-1:0]           win_val_q  [WIN];
	logic [TW-1:0]                  win_time_q [WIN];
	logic [worf_pkg::SEEN_W-1:0]    seen_q;

	worf_pkg::job_t job_in;
	worf_pkg::job_t job_s1, job_s2, job_s3, job_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic signed [VW-1:0]     vals_s1 [WIN];
	logic signed [2*VW-1:0]   sq_full [WIN];
	logic signed [SUM_W-1:0]  sum_c;
	logic [SQ_W-1:0]          sq_s2 [WIN];
	logic signed [SUM_W-1:0]  sum_s2;
	logic [QSUM_W-1:0]        qsum_c;
	logic signed [2*SUM_W-1:0] ssq_full;
	logic signed [DIFF_W-1:0] diff_c;
	logic [QSUM_W-1:0]        qsum_s3;
	logic [VAR_W-1:0]         ssq_s3;
	logic signed [DIFF_W-1:0] diff_s3;
	logic signed [2*DIFF_W-1:0] dsq_full;
	logic [VAR_W-1:0]         quint_c;
	logic [DSQ_W-1:0]         dsq_s4;
	logic [VAR_W-1:0]         var_s4;
	logic                     outlier;

	// classify the arriving sample into result slots
	always_comb begin
		job_in              = '0;
		job_in.slot_a.stamp = win_time_q[WIN-2];
		job_in.slot_a.value = win_val_q[WIN-2];
		job_in.slot_b.stamp = win_time_q[WIN-1];
		job_in.slot_b.value = win_val_q[WIN-1];
		job_in.slot_c.stamp = sample_time;
		job_in.slot_c.value = sample_value;
		job_in.tested       = (seen_q >= worf_pkg::SEEN_TEST);
		job_in.last         = series_end;
		job_in.en[worf_pkg::SLOT_B] = series_end &&
			((seen_q == worf_pkg::SEEN_TAIL) || (seen_q >= worf_pkg::SEEN_TEST));
		job_in.en[worf_pkg::SLOT_C] = (seen_q < worf_pkg::SEEN_HEAD) || series_end;
	end

	// sample counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			if (series_end) begin
				seen_q <= '0;
			end else if (seen_q < worf_pkg::SEEN_MAX) begin
				seen_q <= seen_q + 1'b1;
			end
		end
	end

	// window contents before the fifth sample of a series are never tested
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < WIN - 1; i++) begin
				win_val_q[i]  <= win_val_q[i+1];
				win_time_q[i] <= win_time_q[i+1];
			end
			win_val_q[WIN-1]  <= sample_value;
			win_time_q[WIN-1] <= sample_time;
		end
	end

	// stage 2: squares and sum
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < WIN; i++) begin
			sq_full[i] = (2*VW)'(vals_s1[i]) * (2*VW)'(vals_s1[i]);
			sum_c      = sum_c + SUM_W'(vals_s1[i]);
		end
	end

	// stage 3: sum of squares, squared sum, 5v - S
	always_comb begin
		qsum_c = '0;
		for (int i = 0; i < WIN; i++) begin
			qsum_c = qsum_c + QSUM_W'(sq_s2[i]);
		end
		ssq_full = (2*SUM_W)'(sum_s2) * (2*SUM_W)'(sum_s2);
		diff_c   = (DIFF_W'(job_s2.slot_a.value) <<< 2) + DIFF_W'(job_s2.slot_a.value)
			- DIFF_W'(sum_s2);
	end

	// stage 4: (5v - S)^2 and 5Q - S^2 (never negative)
	always_comb begin
		dsq_full = (2*DIFF_W)'(diff_s3) * (2*DIFF_W)'(diff_s3);
		quint_c  = (VAR_W'(qsum_s3) << 2) + VAR_W'(qsum_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		job_s1 <= job_in;
		for (int i = 0; i < WIN - 1; i++) begin
			vals_s1[i] <= win_val_q[i+1];
		end
		vals_s1[WIN-1] <= sample_value;

		job_s2 <= job_s1;
		for (int i = 0; i < WIN; i++) begin
			sq_s2[i] <= sq_full[i][SQ_W-1:0];
		end
		sum_s2 <= sum_c;

		job_s3  <= job_s2;
		qsum_s3 <= qsum_c;
		ssq_s3  <= ssq_full[VAR_W-1:0];
		diff_s3 <= diff_c;

		job_s4 <= job_s3;
		dsq_s4 <= dsq_full[DSQ_W-1:0];
		var_s4 <= quint_c - ssq_s3;
	end

	// a sample exactly on the bound is kept
	assign outlier = dsq_s4 > DSQ_W'(var_s4);

	always_comb begin
		push_job = job_s4;
		push_job.en[worf_pkg::SLOT_A] = job_s4.tested && !outlier;
		push = valid_s4 && (push_job.en != '0);
	end

	assign inflight = INFL_W'(valid_s1) + INFL_W'(valid_s2) + INFL_W'(valid_s3)
		+ INFL_W'(valid_s4);

	// the final sample of a series is always emitted
	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && job_s4.last) |-> (push && push_job.en[worf_pkg::SLOT_C]))
		else $error("series end without a final result");

endmodule

`default_nettype wire

// File: rtl/worf_back.sv
// worf_back: unpacks queued jobs into single results behind an output register
// depends on worf_pkg (job_t, slot codes)
`timescale 1ns / 1ps
`default_nettype none

module worf_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire worf_pkg::job_t               head,
	input  wire logic                         empty,
	output logic                              pop,
	output logic                              kept_valid,
	input  wire logic                         kept_ready,
	output logic [worf_pkg::TIME_W-1:0]       kept_time,
	output logic signed [worf_pkg::VAL_W-1:0] kept_value,
	output logic                              final_result
);

	localparam int SLOTS = worf_pkg::SLOTS;

	worf_pkg::job_t          work_q;
	logic [SLOTS-1:0]        work_mask_q;
	logic [SLOTS-1:0]        sel;
	logic [SLOTS-1:0]        mask_after;
	logic                    out_load;
	worf_pkg::slot_t         sel_slot;
	logic                    sel_final;

	logic                              kept_valid_q;
	logic [worf_pkg::TIME_W-1:0]       kept_time_q;
	logic signed [worf_pkg::VAL_W-1:0] kept_value_q;
	logic                              final_q;

	// lowest pending slot goes first
	always_comb begin
		sel       = '0;
		sel_slot  = work_q.slot_c;
		sel_final = work_q.last;
		priority if (work_mask_q[worf_pkg::SLOT_A]) begin
			sel[worf_pkg::SLOT_A] = 1'b1;
			sel_slot  = work_q.slot_a;
			sel_final = 1'b0;
		end else if (work_mask_q[worf_pkg::SLOT_B]) begin
			sel[worf_pkg::SLOT_B] = 1'b1;
			sel_slot  = work_q.slot_b;
			sel_final = 1'b0;
		end else begin
			sel[worf_pkg::SLOT_C] = work_mask_q[worf_pkg::SLOT_C];
		end
		out_load   = (work_mask_q != '0) && (!kept_valid_q || kept_ready);
		mask_after = out_load ? (work_mask_q & ~sel) : work_mask_q;
		pop        = (mask_after == '0) && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_mask_q  <= '0;
			kept_valid_q <= 1'b0;
		end else begin
			work_mask_q <= pop ? head.en : mask_after;
			if (out_load) begin
				kept_valid_q <= 1'b1;
			end else if (kept_ready) begin
				kept_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= head;
		end
		if (out_load) begin
			kept_time_q  <= sel_slot.stamp;
			kept_value_q <= sel_slot.value;
			final_q      <= sel_final;
		end
	end

	assign kept_valid   = kept_valid_q;
	assign kept_time    = kept_time_q;
	assign kept_value   = kept_value_q;
	assign final_result = final_q;

	// only jobs with at least one result reach the back
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (work_mask_q != '0))
		else $error("empty job taken from the queue");

endmodule

`default_nettype wire

// File: rtl/window_outlier_reject_filter_top.sv
// window_outlier_reject_filter_top: sliding five-sample outlier reject filter
// depends on worf_pkg, worf_front, worf_queue, worf_back
//
//   channel   direction  handshake                  payload
//   sample    in         sample_valid/sample_ready  sample_time, sample_value, series_end
//   kept      out        kept_valid/kept_ready      kept_time, kept_value, final_result
//
// an item can be taken every cycle while the credit check allows it; one result leaves per cycle at most,
// so the extra results of a series end (up to three results) are absorbed by the job queue
// the first result of an item passes the four-stage statistics pipeline, the queue write,
// the unpack register and the output register
// sample_ready is a credit check: queue fill plus items in the pipeline below queue depth
// reset clears counters, valids and queue pointers; window contents need no reset
// a stalled output only backs up the queue; the front never stalls once an item is in
`timescale 1ns / 1ps
`default_nettype none

module window_outlier_reject_filter_top #(
	parameter int QUEUE_DEPTH = worf_pkg::QUEUE_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output logic                                   sample_ready,
	input  wire logic [worf_pkg::TIME_W-1:0]       sample_time,
	input  wire logic signed [worf_pkg::VAL_W-1:0] sample_value,
	input  wire logic                              series_end,
	output logic                                   kept_valid,
	input  wire logic                              kept_ready,
	output logic [worf_pkg::TIME_W-1:0]            kept_time,
	output logic signed [worf_pkg::VAL_W-1:0]      kept_value,
	output logic                                   final_result
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	// occupancy counts queued jobs plus those still in the front pipeline
	localparam int OCC_W = $clog2(QUEUE_DEPTH + worf_pkg::PIPE_STAGES + 1);

	logic                          accept;
	logic                          push;
	worf_pkg::job_t                push_job;
	logic [worf_pkg::INFL_W-1:0]   inflight;
	worf_pkg::job_t                head;
	logic                          empty;
	logic                          pop;
	logic [CNT_W-1:0]              count;
	logic [OCC_W-1:0]              occupancy;

	// every accepted item is guaranteed a queue slot when it leaves the pipeline
	assign occupancy    = OCC_W'(count) + OCC_W'(inflight);
	assign sample_ready = occupancy < OCC_W'(QUEUE_DEPTH);
	assign accept       = sample_valid && sample_ready;

	// front: window, exact deviation test, slot classification
	worf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sample_time  (sample_time),
		.sample_value (sample_value),
		.series_end   (series_end),
		.push         (push),
		.push_job     (push_job),
		.inflight     (inflight)
	);

	// decoupling queue of classified jobs
	worf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.count    (count)
	);

	// back: one result item per cycle from the job at the queue head, while kept_ready does not stall the output
	worf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.kept_valid   (kept_valid),
		.kept_ready   (kept_ready),
		.kept_time    (kept_time),
		.kept_value   (kept_value),
		.final_result (final_result)
	);

endmodule

`default_nettype wire
